[hdl/isf_pkg.sv]
// shared constants, types and codes for the interval selection block
`default_nettype none

package isf_pkg;

    localparam int TIME_BITS = 10;
    localparam int TIME_VALUES = 1 << TIME_BITS;
    localparam int IDX_W = TIME_BITS + 1;
    localparam int OUT_W = 7;
    localparam int MAX_INTERVALS_DEF = 64;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_LOAD,
        ST_CNT_F,
        ST_CNT_B,
        ST_CNT_W,
        ST_PFX,
        ST_SC_F,
        ST_SC_B,
        ST_SC_W,
        ST_WP_F,
        ST_WP_W,
        ST_SN_O,
        ST_SN_S,
        ST_SN_D,
        ST_EM_R,
        ST_EM_V
    } state_t;

    typedef enum logic [2:0] {
        BW_NONE,
        BW_ZERO_IDX,
        BW_PREFIX,
        BW_INC,
        BW_SCATTER,
        BW_ZERO_FIN
    } bkt_op_t;

    typedef struct packed {
        logic    load_en;
        logic    idx_clr;
        logic    idx_inc;
        logic    fin_rd;
        logic    bkt_rd_idx;
        logic    bkt_rd_fin;
        bkt_op_t bkt_op;
        logic    ord_rd;
        logic    pair_rd;
        logic    keep_test;
        logic    emit_rd;
        logic    run_clr;
        logic    kept_clr;
        logic    n_clr;
    } cmd_t;

    typedef struct packed {
        logic idx_zero;
        logic idx_time_last;
        logic idx_time_end;
        logic idx_n_last;
        logic idx_kept_last;
    } status_t;

endpackage

`default_nettype wire

[hdl/interval_select_by_finish_top.sv]
// top level of the interval selection block: greedy selection by earliest finish
`default_nettype none

// Intervals stream in one per cycle; each transfer carries a start and finish time and tlast
// closes the batch. Up to MAX_INTERVALS intervals are numbered from 1 in arrival order and
// further ones are dropped. After the closing transfer the block sorts the batch by finish time
// with a counting sort over a bucket memory of 2^10 counters, keeps greedily every interval
// whose start is not before the last kept finish, and streams out the kept numbers with the
// total and tlast on the final one. No interval is accepted from the closing transfer until the
// last result transfer. Between the two the block runs a count pass, a prefix pass over every
// bucket, a scatter pass, a bucket wipe and a scan, then reads out each result before offering
// it; the registered memory reads in every pass set the pace. After reset the block clears
// every bucket before it accepts the first interval.
module interval_select_by_finish_top
#(
    parameter int MAX_INTERVALS = isf_pkg::MAX_INTERVALS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [isf_pkg::S_TDATA_W-1:0]  s_tdata,  // start_time, finish_time, zero pad
    input  wire logic                           s_tlast,  // batch_end
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [isf_pkg::M_TDATA_W-1:0]       m_tdata,  // chosen_number, chosen_total, zero pad
    output logic                                m_tlast   // final_result
);

    import isf_pkg::*;

    cmd_t    cmd;
    status_t status;

    logic [OUT_W-1:0] chosen_number;
    logic [OUT_W-1:0] chosen_total;
    logic             final_result;

    isf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .batch_end (s_tlast),
        .m_tready  (m_tready),
        .status    (status),
        .cmd       (cmd),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid)
    );

    isf_datapath
    #(
        .MAX_INTERVALS (MAX_INTERVALS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .start_time    (s_tdata[TIME_BITS-1:0]),
        .finish_time   (s_tdata[2*TIME_BITS-1:TIME_BITS]),
        .status        (status),
        .chosen_number (chosen_number),
        .chosen_total  (chosen_total),
        .final_result  (final_result)
    );

    assign m_tdata = {{(M_TDATA_W - 2 * OUT_W){1'b0}}, chosen_total, chosen_number};
    assign m_tlast = final_result;

endmodule

`default_nettype wire

[hdl/isf_ctrl.sv]
// sequencer for the reset clear and the load, count, prefix, scatter, wipe, scan and emit passes
`default_nettype none

module isf_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    input  wire logic            batch_end,
    input  wire logic            m_tready,
    input  wire isf_pkg::status_t status,
    output isf_pkg::cmd_t        cmd,
    output logic                 s_tready,
    output logic                 m_tvalid
);

    import isf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.bkt_op = BW_NONE;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.bkt_op = BW_ZERO_IDX;
                if (status.idx_time_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_en = 1'b1;
                    if (batch_end)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next = ST_CNT_F;
                    end
                end
            end
            ST_CNT_F:
            begin
                cmd.fin_rd = 1'b1;
                state_next = ST_CNT_B;
            end
            ST_CNT_B:
            begin
                cmd.bkt_rd_fin = 1'b1;
                state_next = ST_CNT_W;
            end
            ST_CNT_W:
            begin
                cmd.bkt_op = BW_INC;
                if (status.idx_n_last)
                begin
                    cmd.idx_clr = 1'b1;
                    cmd.run_clr = 1'b1;
                    state_next = ST_PFX;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = ST_CNT_F;
                end
            end
            ST_PFX:
            begin
                cmd.bkt_rd_idx = 1'b1;
                if (!status.idx_zero)
                begin
                    cmd.bkt_op = BW_PREFIX;
                end
                if (status.idx_time_end)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next = ST_SC_F;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_SC_F:
            begin
                cmd.fin_rd = 1'b1;
                state_next = ST_SC_B;
            end
            ST_SC_B:
            begin
                cmd.bkt_rd_fin = 1'b1;
                state_next = ST_SC_W;
            end
            ST_SC_W:
            begin
                cmd.bkt_op = BW_SCATTER;
                if (status.idx_n_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next = ST_WP_F;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = ST_SC_F;
                end
            end
            ST_WP_F:
            begin
                cmd.fin_rd = 1'b1;
                state_next = ST_WP_W;
            end
            ST_WP_W:
            begin
                cmd.bkt_op = BW_ZERO_FIN;
                if (status.idx_n_last)
                begin
                    cmd.idx_clr = 1'b1;
                    cmd.kept_clr = 1'b1;
                    state_next = ST_SN_O;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = ST_WP_F;
                end
            end
            ST_SN_O:
            begin
                cmd.ord_rd = 1'b1;
                state_next = ST_SN_S;
            end
            ST_SN_S:
            begin
                cmd.pair_rd = 1'b1;
                state_next = ST_SN_D;
            end
            ST_SN_D:
            begin
                cmd.keep_test = 1'b1;
                if (status.idx_n_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next = ST_EM_R;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = ST_SN_O;
                end
            end
            ST_EM_R:
            begin
                cmd.emit_rd = 1'b1;
                state_next = ST_EM_V;
            end
            ST_EM_V:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (status.idx_kept_last)
                    begin
                        cmd.idx_clr = 1'b1;
                        cmd.n_clr = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next = ST_EM_R;
                    end
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/isf_datapath.sv]
// interval stores, finish-time buckets, sort order, greedy test and result list
`default_nettype none

module isf_datapath
#(
    parameter int MAX_INTERVALS = isf_pkg::MAX_INTERVALS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire isf_pkg::cmd_t                cmd,
    input  wire logic [isf_pkg::TIME_BITS-1:0] start_time,
    input  wire logic [isf_pkg::TIME_BITS-1:0] finish_time,
    output isf_pkg::status_t                  status,
    output logic [isf_pkg::OUT_W-1:0]         chosen_number,
    output logic [isf_pkg::OUT_W-1:0]         chosen_total,
    output logic                              final_result
);

    import isf_pkg::*;

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int NW = $clog2(MAX_INTERVALS + 1);
    localparam int TB = TIME_BITS;

    logic [TB-1:0] start_mem  [MAX_INTERVALS];
    logic [TB-1:0] finish_mem [MAX_INTERVALS];
    logic [AW-1:0] order_mem  [MAX_INTERVALS];
    logic [AW-1:0] chosen_mem [MAX_INTERVALS];
    logic [NW-1:0] bucket_mem [TIME_VALUES];

    logic [NW-1:0]    n_reg;
    logic [NW-1:0]    n_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [NW-1:0]    run_reg;
    logic [NW-1:0]    run_next;
    logic [NW-1:0]    kept_reg;
    logic [NW-1:0]    kept_next;

    logic [TB-1:0] fin_rd_reg;
    logic [TB-1:0] st_rd_reg;
    logic [AW-1:0] ord_rd_reg;
    logic [NW-1:0] bkt_rd_reg;
    logic [AW-1:0] chosen_rd_reg;
    logic [TB-1:0] last_fin_reg;

    logic             load_wr;
    logic             keep;
    logic [AW-1:0]    fin_addr;
    logic [TB-1:0]    bkt_rd_addr;
    logic [TB-1:0]    bkt_wr_addr;
    logic [NW-1:0]    bkt_wr_data;
    logic             bkt_wr_en;
    logic [IDX_W-1:0] idx_dec;

    assign load_wr     = cmd.load_en && (n_reg < NW'(MAX_INTERVALS));
    assign keep        = (idx_reg == '0) || (st_rd_reg >= last_fin_reg);
    assign fin_addr    = cmd.pair_rd ? ord_rd_reg : idx_reg[AW-1:0];
    assign bkt_rd_addr = cmd.bkt_rd_idx ? idx_reg[TB-1:0] : fin_rd_reg;
    assign bkt_wr_en   = (cmd.bkt_op != BW_NONE);
    assign idx_dec     = idx_reg - IDX_W'(1);

    always_comb
    begin
        unique case (cmd.bkt_op)
            BW_ZERO_IDX: bkt_wr_addr = idx_reg[TB-1:0];
            BW_PREFIX:   bkt_wr_addr = idx_dec[TB-1:0];
            default:     bkt_wr_addr = fin_rd_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.bkt_op)
            // empty buckets stay zero so the wipe only visits finish times in the batch
            BW_PREFIX:             bkt_wr_data = (bkt_rd_reg == '0) ? '0 : run_reg;
            BW_INC, BW_SCATTER:    bkt_wr_data = bkt_rd_reg + NW'(1);
            default:               bkt_wr_data = '0;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            start_mem[n_reg[AW-1:0]]  <= start_time;
            finish_mem[n_reg[AW-1:0]] <= finish_time;
        end
        if (cmd.fin_rd || cmd.pair_rd)
        begin
            fin_rd_reg <= finish_mem[fin_addr];
        end
        if (cmd.pair_rd)
        begin
            st_rd_reg <= start_mem[ord_rd_reg];
        end
        if (bkt_wr_en)
        begin
            bucket_mem[bkt_wr_addr] <= bkt_wr_data;
        end
        if (cmd.bkt_rd_idx || cmd.bkt_rd_fin)
        begin
            bkt_rd_reg <= bucket_mem[bkt_rd_addr];
        end
        if (cmd.bkt_op == BW_SCATTER)
        begin
            order_mem[bkt_rd_reg[AW-1:0]] <= idx_reg[AW-1:0];
        end
        if (cmd.ord_rd)
        begin
            ord_rd_reg <= order_mem[idx_reg[AW-1:0]];
        end
        if (cmd.keep_test && keep)
        begin
            chosen_mem[kept_reg[AW-1:0]] <= ord_rd_reg;
            last_fin_reg <= fin_rd_reg;
        end
        if (cmd.emit_rd)
        begin
            chosen_rd_reg <= chosen_mem[idx_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        n_next = n_reg;
        if (cmd.n_clr)
        begin
            n_next = '0;
        end
        else if (load_wr)
        begin
            n_next = n_reg + NW'(1);
        end

        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        run_next = run_reg;
        if (cmd.run_clr)
        begin
            run_next = '0;
        end
        else if (cmd.bkt_op == BW_PREFIX)
        begin
            run_next = run_reg + bkt_rd_reg;
        end

        kept_next = kept_reg;
        if (cmd.kept_clr)
        begin
            kept_next = '0;
        end
        else if (cmd.keep_test && keep)
        begin
            kept_next = kept_reg + NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            idx_reg  <= '0;
            run_reg  <= '0;
            kept_reg <= '0;
        end
        else
        begin
            n_reg    <= n_next;
            idx_reg  <= idx_next;
            run_reg  <= run_next;
            kept_reg <= kept_next;
        end
    end

    assign status.idx_zero      = (idx_reg == '0);
    assign status.idx_time_last = (idx_reg == IDX_W'(TIME_VALUES - 1));
    assign status.idx_time_end  = (idx_reg == IDX_W'(TIME_VALUES));
    assign status.idx_n_last    = (idx_reg == IDX_W'(n_reg) - IDX_W'(1));
    assign status.idx_kept_last = (idx_reg == IDX_W'(kept_reg) - IDX_W'(1));

    assign chosen_number = OUT_W'(chosen_rd_reg) + OUT_W'(1);
    assign chosen_total  = OUT_W'(kept_reg);
    assign final_result  = status.idx_kept_last;

endmodule

`default_nettype wire

[tb/sv/interval_select_by_finish_top_test.sv]
// self-checking stream testbench for the interval selection block
`timescale 1ns / 100ps

module interval_select_by_finish_top_test;

    localparam int TB = isf_pkg::TIME_BITS;
    localparam int OW = isf_pkg::OUT_W;
    localparam int MAXN = isf_pkg::MAX_INTERVALS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [TB-1:0] start_t;
        logic [TB-1:0] finish_t;
        logic          closes;
    } interval_t;

    typedef struct packed {
        logic [OW-1:0] number;
        logic [OW-1:0] total;
        logic          is_final;
    } choice_t;

    typedef enum int {
        MODE_WIDE,
        MODE_NARROW,
        MODE_CHAIN,
        MODE_EDGES
    } spread_t;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [isf_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [isf_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;

    interval_t     interval_q[$];
    choice_t       chosen_q[$];
    logic [TB-1:0] batch_start[MAXN];
    logic [TB-1:0] batch_finish[MAXN];
    int            batch_len = 0;
    int            total_items = 0;
    int            sent_count = 0;
    int            err_count = 0;
    int            result_count = 0;
    logic          quiet_tail = 1'b0;

    interval_select_by_finish_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
        err_count++;
    endtask

    // stable sort by finish, then greedy keep on start >= last kept finish
    task automatic select_by_finish(input logic [TB-1:0] st, input logic [TB-1:0] fin,
                                    input logic closes);
        int            order[$];
        int            kept[$];
        int            pos;
        int            i;
        logic [TB-1:0] last_fin;
        choice_t       c;
        if (batch_len < MAXN)
        begin
            batch_start[batch_len] = st;
            batch_finish[batch_len] = fin;
            batch_len++;
        end
        if (closes)
        begin
            for (i = 0; i < batch_len; i++)
            begin
                pos = order.size();
                while (pos > 0 && batch_finish[order[pos-1]] > batch_finish[i])
                    pos--;
                order.insert(pos, i);
            end
            kept.insert(kept.size(), order[0]);
            last_fin = batch_finish[order[0]];
            for (i = 1; i < order.size(); i++)
            begin
                if (batch_start[order[i]] >= last_fin)
                begin
                    kept.insert(kept.size(), order[i]);
                    last_fin = batch_finish[order[i]];
                end
            end
            for (i = 0; i < kept.size(); i++)
            begin
                c.number = OW'(kept[i] + 1);
                c.total = OW'(kept.size());
                c.is_final = (i == kept.size() - 1);
                chosen_q.insert(chosen_q.size(), c);
            end
            batch_len = 0;
        end
    endtask

    task automatic add_interval(input int st, input int fin, input logic closes);
        interval_t it;
        it.start_t = TB'(st);
        it.finish_t = TB'(fin);
        it.closes = closes;
        interval_q.insert(interval_q.size(), it);
        total_items++;
    endtask

    task automatic add_batch(input int len, input spread_t mode);
        int cursor;
        int st;
        int fin;
        int i;
        cursor = $urandom_range(0, 40);
        for (i = 0; i < len; i++)
        begin
            case (mode)
                MODE_NARROW:
                begin
                    st = $urandom_range(0, 15);
                    fin = $urandom_range(0, 15);
                end
                MODE_CHAIN:
                begin
                    st = cursor;
                    fin = cursor + $urandom_range(0, 30);
                    if (fin > 1023)
                        fin = 1023;
                    cursor = fin + $urandom_range(0, 8) - 2;
                    if (cursor < 0)
                        cursor = 0;
                    if (cursor > 1023)
                        cursor = $urandom_range(0, 1023);
                end
                MODE_EDGES:
                begin
                    st = ($urandom_range(0, 1) == 1) ? $urandom_range(1008, 1023)
                                                     : $urandom_range(0, 15);
                    fin = ($urandom_range(0, 1) == 1) ? $urandom_range(1008, 1023)
                                                      : $urandom_range(0, 15);
                end
                default:
                begin
                    st = $urandom_range(0, 1023);
                    fin = $urandom_range(0, 1023);
                end
            endcase
            add_interval(st, fin, i == len - 1);
        end
    endtask

    // stimulus plan and end of run
    initial
    begin
        int len;
        spread_t mode;

        add_interval(0, 0, 1'b1);

        add_interval(1023, 1023, 1'b0);
        add_interval(0, 1023, 1'b0);
        add_interval(1023, 0, 1'b1);

        // zero-length intervals at one time and a longer one with the same finish, ties broken by arrival
        add_interval(5, 5, 1'b0);
        add_interval(5, 5, 1'b0);
        add_interval(5, 5, 1'b0);
        add_interval(3, 5, 1'b1);

        add_interval(10, 20, 1'b0);
        add_interval(0, 20, 1'b0);
        add_interval(20, 30, 1'b0);
        add_interval(25, 30, 1'b1);

        add_interval(0, 100, 1'b0);
        add_interval(100, 200, 1'b0);
        add_interval(50, 150, 1'b0);
        add_interval(200, 1023, 1'b1);

        // overfull batch closed by a dropped interval
        add_batch(66, MODE_CHAIN);

        while (total_items < 214)
        begin
            mode = spread_t'($urandom_range(0, 3));
            if ($urandom_range(0, 14) == 0)
                len = $urandom_range(62, 68);
            else
                len = $urandom_range(1, 12);
            add_batch(len, mode);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (sent_count == total_items);
        wait (chosen_q.size() == 0);
        repeat (60) @(posedge clk);
        if (err_count == 0 && chosen_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // interval sender
    always @(posedge clk or negedge rst_n)
    begin
        int        idle_left;
        interval_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            idle_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                select_by_finish(s_tdata[TB-1:0], s_tdata[2*TB-1:TB], s_tlast);
                sent_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    s_tvalid <= 1'b0;
                end
                else if (interval_q.size() > 0)
                begin
                    it = interval_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(isf_pkg::S_TDATA_W - 2*TB){1'b0}}, it.finish_t, it.start_t};
                    s_tlast <= it.closes;
                    quiet_tail <= (interval_q.size() < 40);
                    if (interval_q.size() >= 40 && $urandom_range(0, 6) == 0)
                        idle_left = $urandom_range(1, 19);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        int      stall_left;
        int      hold_left;
        logic    hold_done;
        choice_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (chosen_q.size() == 0)
                begin
                    report_mismatch("unexpected transfer, number", int'(m_tdata[OW-1:0]), 0);
                end
                else
                begin
                    want = chosen_q.pop_front();
                    if (m_tdata[OW-1:0] !== want.number)
                        report_mismatch("chosen_number", int'(m_tdata[OW-1:0]),
                                        int'(want.number));
                    if (m_tdata[2*OW-1:OW] !== want.total)
                        report_mismatch("chosen_total", int'(m_tdata[2*OW-1:OW]),
                                        int'(want.total));
                    if (m_tlast !== want.is_final)
                        report_mismatch("final_result", int'(m_tlast), int'(want.is_final));
                end
                result_count++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && m_tvalid && result_count >= 20 && interval_q.size() > 20)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 19);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        int quiet_cycles;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

[interval_select_by_finish_top.f]
hdl/isf_pkg.sv
hdl/isf_ctrl.sv
hdl/isf_datapath.sv
hdl/interval_select_by_finish_top.sv
tb/sv/interval_select_by_finish_top_test.sv
